@@ design/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker package
// Types, character constants and code tables shared by the checker modules.
// ----------------------------------------------------------------------------
package bbc_pkg;

   // Kind of an open bracket as held in one stack cell.
   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_BRACE  = 2'd1,
      KIND_SQUARE = 2'd2,
      KIND_PAREN  = 2'd3
   } kind_type;

   // Status codes carried by each result beat.
   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_MISMATCH = 3'd1,
      STATUS_UNCLOSED = 3'd2,
      STATUS_BALANCED = 3'd3,
      STATUS_OVERFLOW = 3'd4,
      STATUS_HALTED   = 3'd5
   } status_type;

   localparam logic [7:0]  CH_LBRACE  = 8'h7B;
   localparam logic [7:0]  CH_RBRACE  = 8'h7D;
   localparam logic [7:0]  CH_LSQUARE = 8'h5B;
   localparam logic [7:0]  CH_RSQUARE = 8'h5D;
   localparam logic [7:0]  CH_LPAREN  = 8'h28;
   localparam logic [7:0]  CH_RPAREN  = 8'h29;
   localparam logic [7:0]  CH_NEWLINE = 8'h0A;
   localparam logic [7:0]  CH_NONE    = 8'h00;
   localparam logic [23:0] LINE_MAX   = 24'hFFFFFF;
   localparam logic [23:0] LINE_FIRST = 24'd1;

   // One input beat.
   typedef struct packed {
      logic [7:0] character;
      logic       end_of_text;
   } req_type;

   // One result beat.
   typedef struct packed {
      status_type  status;
      logic [23:0] line_number;
      logic [7:0]  expected_char;
      logic [7:0]  found_char;
   } rsp_type;

   // Shift controls broadcast to every stack cell.
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctl_type;

   // Map an opening bracket to its kind, anything else to none.
   function automatic kind_type opener_kind(input logic [7:0] ch);
      kind_type k;
      k = KIND_NONE;
      if (ch == CH_LBRACE) k = KIND_BRACE;
      else if (ch == CH_LSQUARE) k = KIND_SQUARE;
      else if (ch == CH_LPAREN) k = KIND_PAREN;
      return k;
   endfunction

   // Map a closing bracket to its kind, anything else to none.
   function automatic kind_type closer_kind(input logic [7:0] ch);
      kind_type k;
      k = KIND_NONE;
      if (ch == CH_RBRACE) k = KIND_BRACE;
      else if (ch == CH_RSQUARE) k = KIND_SQUARE;
      else if (ch == CH_RPAREN) k = KIND_PAREN;
      return k;
   endfunction

   // Closing character for a bracket kind.
   function automatic logic [7:0] closer_char(input kind_type k);
      logic [7:0] c;
      case (k)
         KIND_BRACE:  c = CH_RBRACE;
         KIND_SQUARE: c = CH_RSQUARE;
         KIND_PAREN:  c = CH_RPAREN;
         default:     c = CH_NONE;
      endcase
      return c;
   endfunction

endpackage

@@ design/bbc_cell.sv @@
// ----------------------------------------------------------------------------
// Bracket stack cell
// One entry of the shifting stack; takes its upper neighbor on a push and its
// lower neighbor on a pop.
// ----------------------------------------------------------------------------
module bbc_cell (
   input  logic                  clock,
   input  bbc_pkg::cell_ctl_type ctl,
   input  bbc_pkg::kind_type     upper_kind,
   input  bbc_pkg::kind_type     lower_kind,
   output bbc_pkg::kind_type     kind
);
   import bbc_pkg::*;

   kind_type kind_ff;
   kind_type kind_in;

   // Select the next entry from the neighbors.
   always_comb begin
      kind_in = kind_ff;
      if (ctl.push) begin
         kind_in = upper_kind;
      end else if (ctl.pop) begin
         kind_in = lower_kind;
      end
   end

   // Entry storage carries no reset; only entries below the count are read.
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign kind = kind_ff;

endmodule

@@ design/bbc_skid.sv @@
// ----------------------------------------------------------------------------
// Result skid buffer
// Output register plus one skid entry so the checker keeps taking beats while
// a result waits for the receiver.
// ----------------------------------------------------------------------------
module bbc_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  bbc_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output bbc_pkg::rsp_type out_data
);
   import bbc_pkg::*;

   logic    out_valid_ff;
   logic    out_valid_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;
   logic    take;
   logic    drain;

   assign in_ready = !skid_valid_ff;
   assign take     = in_valid && !skid_valid_ff;
   assign drain    = out_valid_ff && out_ready;

   // Move beats between the skid entry and the output register.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (drain) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (take) begin
         if (!out_valid_ff || drain) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (drain) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

@@ design/bracket_balance_checker.sv @@
// ----------------------------------------------------------------------------
// Bracket balance checker
// Checks that { [ ( are closed in order by } ] ) over a stream of text bytes.
// ----------------------------------------------------------------------------
// The req_ channel takes one beat per text byte, or an end-of-text beat that
// reports the final verdict and clears the checker for the next text. Every
// request beat yields exactly one rsp_ beat with a status, the current line,
// the closer that matches the innermost open bracket and the offending byte.
// A beat is processed in the cycle it is accepted. Its result is registered in
// the output register, or in the skid entry while that register is held, and
// one beat is accepted every cycle while req_ready is high. The stack is a row
// of STACK_DEPTH cells that all shift together, so push, pop and the compare on
// the top entry happen in the cycle the beat is accepted. A mismatch or a stack
// overflow halts checking until the next end-of-text beat. When the receiver
// stalls, one result is held in the output register and one more in a skid
// entry; req_ready drops only when both are full. Reset empties the stack, sets
// the line count to one, clears the halt and discards any results not yet taken.
// ----------------------------------------------------------------------------
module bracket_balance_checker #(
   parameter int STACK_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bbc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bbc_pkg::rsp_type rsp_payload
);
   import bbc_pkg::*;

   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);
   localparam logic [SP_W-1:0] SP_ONE  = SP_W'(1);

   logic [SP_W-1:0] sp_ff;
   logic [SP_W-1:0] sp_in;
   logic [23:0]     line_ff;
   logic [23:0]     line_in;
   logic            halted_ff;
   logic            halted_in;

   logic            accept;
   cell_ctl_type    ctl;
   kind_type        push_kind;
   kind_type        cell_kind [STACK_DEPTH];
   kind_type        op_kind;
   kind_type        cl_kind;
   rsp_type         result;

   assign accept    = req_valid && req_ready;
   assign op_kind   = opener_kind(req_payload.character);
   assign cl_kind   = closer_kind(req_payload.character);
   assign push_kind = op_kind;

   // Decide the step for the accepted beat and build its result.
   always_comb begin
      sp_in                = sp_ff;
      line_in              = line_ff;
      halted_in            = halted_ff;
      ctl.push             = 1'b0;
      ctl.pop              = 1'b0;
      result.status        = STATUS_OK;
      result.line_number   = line_ff;
      result.found_char    = CH_NONE;
      result.expected_char = (sp_ff != '0) ? closer_char(cell_kind[0]) : CH_NONE;
      if (req_payload.end_of_text) begin
         if (halted_ff) begin
            result.status = STATUS_HALTED;
         end else if (sp_ff != '0) begin
            result.status = STATUS_UNCLOSED;
         end else begin
            result.status = STATUS_BALANCED;
         end
         sp_in     = '0;
         line_in   = LINE_FIRST;
         halted_in = 1'b0;
      end else if (halted_ff) begin
         result.status = STATUS_HALTED;
      end else if (req_payload.character == CH_NEWLINE) begin
         if (line_ff != LINE_MAX) begin
            line_in = line_ff + 24'd1;
         end
         result.line_number = line_in;
      end else if (op_kind != KIND_NONE) begin
         if (sp_ff == SP_FULL) begin
            result.status     = STATUS_OVERFLOW;
            result.found_char = req_payload.character;
            halted_in         = 1'b1;
         end else begin
            ctl.push             = 1'b1;
            sp_in                = sp_ff + SP_ONE;
            result.expected_char = closer_char(op_kind);
         end
      end else if (cl_kind != KIND_NONE) begin
         if (sp_ff != '0 && cell_kind[0] == cl_kind) begin
            ctl.pop              = 1'b1;
            sp_in                = sp_ff - SP_ONE;
            result.expected_char = (sp_ff == SP_ONE) ? CH_NONE : closer_char(cell_kind[1]);
         end else begin
            result.status     = STATUS_MISMATCH;
            result.found_char = req_payload.character;
            halted_in         = 1'b1;
         end
      end
      if (!accept) begin
         ctl.push  = 1'b0;
         ctl.pop   = 1'b0;
         sp_in     = sp_ff;
         line_in   = line_ff;
         halted_in = halted_ff;
      end
   end

   // Control state: stack count, line count and halt flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff     <= '0;
         line_ff   <= LINE_FIRST;
         halted_ff <= 1'b0;
      end else begin
         sp_ff     <= sp_in;
         line_ff   <= line_in;
         halted_ff <= halted_in;
      end
   end

   // Row of stack cells; cell zero holds the innermost open bracket.
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_top
         bbc_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .upper_kind (push_kind),
            .lower_kind (cell_kind[1]),
            .kind       (cell_kind[0])
         );
      end else if (i == STACK_DEPTH - 1) begin : g_bottom
         bbc_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .upper_kind (cell_kind[i-1]),
            .lower_kind (KIND_NONE),
            .kind       (cell_kind[i])
         );
      end else begin : g_mid
         bbc_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .upper_kind (cell_kind[i-1]),
            .lower_kind (cell_kind[i+1]),
            .kind       (cell_kind[i])
         );
      end
   end

   // Result beats leave through the output register and skid entry.
   bbc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_payload)
   );

endmodule
